FILE: rtl/prq_pkg.sv
// Package for the priority ready-queue scheduler.
// Transaction types, operation and status codes, controller/datapath interface.
// No dependencies.
package prq_pkg;

  localparam int unsigned NumThreadsDef = 32;
  localparam int unsigned PidW          = 5;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_EXIT   = 2'd2,
    OP_REAP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PidW-1:0] new_pid;
    logic [PidW-1:0] current_pid;
    logic            current_valid;
  } res_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_FREE_STEP,
    DP_ZOMB,
    DP_CMP_START,
    DP_CMP_RD,
    DP_CMP_CHK,
    DP_CMP_END,
    DP_PR_RD,
    DP_PR_LAT,
    DP_INS_RDQ,
    DP_INS_RDP,
    DP_INS_DEC,
    DP_INS_HEAD,
    DP_PICK_CHK,
    DP_PICK_NONE
  } dp_cmd_e;

  typedef struct packed {
    op_e  op;
    logic free_hit;
    logic scan_last;
    logic idx_zero;
    logic idx_at_count;
    logic prio_gt;
    logic zombie_hit;
    logic present;
  } dp_stat_t;

endpackage

FILE: rtl/prq_datapath.sv
// Datapath: slot flags, priority and queue memories, counters and result registers.
// Depends on prq_pkg; driven by prq_ctrl commands.
module prq_datapath #(
  parameter int unsigned NUM_THREADS = prq_pkg::NumThreadsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prq_pkg::req_t     req_i,
  input  prq_pkg::dp_cmd_e  cmd_i,
  output prq_pkg::dp_stat_t stat_o,
  output prq_pkg::res_t     res_o
);
  import prq_pkg::*;

  localparam int unsigned IW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int unsigned CW = $clog2(NUM_THREADS + 1);

  op_e                  op_q;
  logic [7:0]           pr_q;
  logic [NUM_THREADS-1:0] used_q, zomb_q;
  logic [IW-1:0]        cur_q;
  logic                 pres_q;
  logic [CW-1:0]        cnt_q, idx_q, wr_q;
  logic [IW-1:0]        ins_pid_q, qv_q, new_pid_q;
  logic [7:0]           ins_pr_q;
  logic [1:0]           status_q;

  logic [IW-1:0] qmem [NUM_THREADS];
  logic [7:0]    pmem [NUM_THREADS];
  logic [IW-1:0] q_rdata;
  logic [7:0]    p_rdata;

  logic [IW-1:0] idx_a, idx_m1, q_raddr, q_waddr, q_wdata, p_raddr;
  logic [CW-1:0] idx_dec;
  logic          q_we, p_we, skip, free_hit, prio_gt;

  assign idx_a    = idx_q[IW-1:0];
  assign idx_dec  = idx_q - CW'(1);
  assign idx_m1   = idx_dec[IW-1:0];
  assign free_hit = !used_q[idx_a];
  assign prio_gt  = p_rdata > ins_pr_q;
  assign skip     = (op_q == OP_REAP) ? zomb_q[q_rdata] : (q_rdata == cur_q);

  assign q_raddr = (cmd_i == DP_INS_RDQ) ? idx_m1 : idx_a;
  assign p_raddr = (cmd_i == DP_INS_RDP) ? q_rdata : cur_q;
  assign p_we    = (cmd_i == DP_FREE_STEP) && free_hit;

  always_comb begin
    q_we    = 1'b0;
    q_waddr = idx_a;
    q_wdata = ins_pid_q;
    case (cmd_i)
      DP_CMP_CHK: begin
        q_we    = !skip;
        q_waddr = wr_q[IW-1:0];
        q_wdata = q_rdata;
      end
      DP_INS_DEC: begin
        q_we    = 1'b1;
        q_wdata = prio_gt ? qv_q : ins_pid_q;
      end
      DP_INS_HEAD: begin
        q_we    = 1'b1;
        q_waddr = '0;
      end
      default: q_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    q_rdata <= qmem[q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pmem[idx_a] <= pr_q;
    p_rdata <= pmem[p_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= OP_CREATE;
      pr_q      <= '0;
      used_q    <= '0;
      zomb_q    <= '0;
      cur_q     <= '0;
      pres_q    <= 1'b0;
      cnt_q     <= '0;
      idx_q     <= '0;
      wr_q      <= '0;
      ins_pid_q <= '0;
      ins_pr_q  <= '0;
      qv_q      <= '0;
      new_pid_q <= '0;
      status_q  <= ST_OK;
    end else begin
      case (cmd_i)
        DP_LOAD: begin
          op_q      <= req_i.op;
          pr_q      <= req_i.priority_req;
          status_q  <= ST_OK;
          new_pid_q <= '0;
        end
        DP_FREE_STEP: begin
          if (free_hit) begin
            used_q[idx_a] <= 1'b1;
            zomb_q[idx_a] <= 1'b0;
            ins_pid_q     <= idx_a;
            ins_pr_q      <= pr_q;
            new_pid_q     <= idx_a;
            idx_q         <= cnt_q;
          end else if (idx_q == CW'(NUM_THREADS - 1)) begin
            status_q <= ST_FULL;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        DP_ZOMB: begin
          if (pres_q) zomb_q[cur_q] <= 1'b1;
        end
        DP_CMP_START: begin
          idx_q <= '0;
          wr_q  <= '0;
        end
        DP_CMP_CHK: begin
          if (skip) begin
            if (op_q == OP_REAP) begin
              used_q[q_rdata] <= 1'b0;
              zomb_q[q_rdata] <= 1'b0;
              if (pres_q && cur_q == q_rdata) begin
                pres_q <= 1'b0;
                cur_q  <= '0;
              end
            end
          end else begin
            wr_q <= wr_q + CW'(1);
          end
          idx_q <= idx_q + CW'(1);
        end
        DP_CMP_END: begin
          cnt_q <= wr_q;
          idx_q <= '0;
        end
        DP_PR_LAT: begin
          ins_pr_q  <= p_rdata;
          ins_pid_q <= cur_q;
          idx_q     <= cnt_q;
        end
        DP_INS_RDP: qv_q <= q_rdata;
        DP_INS_DEC: begin
          if (prio_gt) begin
            idx_q <= idx_dec;
          end else begin
            cnt_q <= cnt_q + CW'(1);
            idx_q <= '0;
          end
        end
        DP_INS_HEAD: begin
          cnt_q <= cnt_q + CW'(1);
          idx_q <= '0;
        end
        DP_PICK_CHK: begin
          if (!zomb_q[q_rdata]) begin
            cur_q  <= q_rdata;
            pres_q <= 1'b1;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        DP_PICK_NONE: begin
          cur_q    <= '0;
          pres_q   <= 1'b0;
          status_q <= ST_NONE;
        end
        default: idx_q <= idx_q;
      endcase
    end
  end

  assign stat_o.op           = op_q;
  assign stat_o.free_hit     = free_hit;
  assign stat_o.scan_last    = idx_q == CW'(NUM_THREADS - 1);
  assign stat_o.idx_zero     = idx_q == '0;
  assign stat_o.idx_at_count = idx_q == cnt_q;
  assign stat_o.prio_gt      = prio_gt;
  assign stat_o.zombie_hit   = zomb_q[q_rdata];
  assign stat_o.present      = pres_q;

  assign res_o.status        = status_q;
  assign res_o.new_pid       = PidW'(new_pid_q);
  assign res_o.current_pid   = PidW'(cur_q);
  assign res_o.current_valid = pres_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NUM_THREADS))
    else $error("queue count above table size");
  a_zomb_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zomb_q & ~used_q) == '0)
    else $error("zombie flag on a free slot");
  a_cur_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pres_q |-> used_q[cur_q])
    else $error("current thread on a free slot");

endmodule

FILE: rtl/prq_ctrl.sv
// Controller: one-hot sequencer stepping the datapath through each operation.
// Depends on prq_pkg; drives prq_datapath.
module prq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  prq_pkg::dp_stat_t stat_i,
  output logic              busy,
  output logic              done_o,
  output prq_pkg::dp_cmd_e  cmd_o
);
  import prq_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DISPATCH = 14'b00000000000010,
    S_FREE     = 14'b00000000000100,
    S_ZOMB     = 14'b00000000001000,
    S_CMP_RD   = 14'b00000000010000,
    S_CMP_CHK  = 14'b00000000100000,
    S_PR_RD    = 14'b00000001000000,
    S_PR_LAT   = 14'b00000010000000,
    S_INS_RDQ  = 14'b00000100000000,
    S_INS_RDP  = 14'b00001000000000,
    S_INS_DEC  = 14'b00010000000000,
    S_PICK_RD  = 14'b00100000000000,
    S_PICK_CHK = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  state_e ins_exit;

  assign ins_exit = (stat_i.op == OP_CREATE) ? S_DONE : S_PICK_RD;

  always_comb begin
    state_d = state_q;
    cmd_o   = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = DP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o = DP_CMP_START;
        case (stat_i.op)
          OP_CREATE: state_d = S_FREE;
          OP_EXIT:   state_d = S_ZOMB;
          OP_REAP:   state_d = S_CMP_RD;
          default:   state_d = stat_i.present ? S_CMP_RD : S_PICK_RD;
        endcase
      end
      S_FREE: begin
        cmd_o = DP_FREE_STEP;
        if (stat_i.free_hit) state_d = S_INS_RDQ;
        else if (stat_i.scan_last) state_d = S_DONE;
      end
      S_ZOMB: begin
        cmd_o   = DP_ZOMB;
        state_d = stat_i.present ? S_CMP_RD : S_PICK_RD;
      end
      S_CMP_RD: begin
        if (stat_i.idx_at_count) begin
          cmd_o   = DP_CMP_END;
          state_d = (stat_i.op == OP_REAP) ? S_DONE : S_PR_RD;
        end else begin
          cmd_o   = DP_CMP_RD;
          state_d = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        cmd_o   = DP_CMP_CHK;
        state_d = S_CMP_RD;
      end
      S_PR_RD: begin
        cmd_o   = DP_PR_RD;
        state_d = S_PR_LAT;
      end
      S_PR_LAT: begin
        cmd_o   = DP_PR_LAT;
        state_d = S_INS_RDQ;
      end
      S_INS_RDQ: begin
        if (stat_i.idx_zero) begin
          cmd_o   = DP_INS_HEAD;
          state_d = ins_exit;
        end else begin
          cmd_o   = DP_INS_RDQ;
          state_d = S_INS_RDP;
        end
      end
      S_INS_RDP: begin
        cmd_o   = DP_INS_RDP;
        state_d = S_INS_DEC;
      end
      S_INS_DEC: begin
        cmd_o   = DP_INS_DEC;
        state_d = stat_i.prio_gt ? S_INS_RDQ : ins_exit;
      end
      S_PICK_RD: begin
        if (stat_i.idx_at_count) begin
          cmd_o   = DP_PICK_NONE;
          state_d = S_DONE;
        end else begin
          state_d = S_PICK_CHK;
        end
      end
      S_PICK_CHK: begin
        cmd_o   = DP_PICK_CHK;
        state_d = stat_i.zombie_hit ? S_PICK_RD : S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("sequencer not idle after result");

endmodule

FILE: rtl/priority_ready_queue_scheduler.sv
// Priority ready-queue scheduler: top level joining prq_ctrl and prq_datapath.
// Operations: create scans up to NUM_THREADS slots for a free one, then inserts the new
// thread by priority; yield/exit remove the current thread (if any) from the queue, re-insert
// it by priority and pick the next non-zombie entry; reap removes zombie entries.
// Throughput: one transaction at a time; busy holds until the one-cycle done_o strobe.
// Reset clears flags, count and current thread at once; queue and priority memories need none.
module priority_ready_queue_scheduler #(
  parameter int unsigned NUM_THREADS = prq_pkg::NumThreadsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  prq_pkg::req_t req_i,
  output logic          done_o,
  output prq_pkg::res_t res_o
);
  import prq_pkg::*;

  dp_cmd_e  cmd;
  dp_stat_t stat;

  prq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  prq_datapath #(
    .NUM_THREADS (NUM_THREADS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule
